>>> src/lkgm_pkg.sv
// Package for the linear-kernel Gram matrix core: field widths, register indexes,
// reset values and the control struct passed from the sequencer to the MAC unit.
// No dependencies.
package lkgm_pkg;

  // Field widths of the element, kernel result and index ports.
  localparam int ElemW    = 16;
  localparam int ProdW    = 2 * ElemW;
  localparam int KernW    = 36;
  localparam int IdxW     = 3;

  // Configuration register widths and port widths.
  localparam int RowsW    = 4;
  localparam int ColsW    = 5;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 5;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] CfgRowsInUse = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgColsInUse = 2'd1;

  // Register values after reset.
  localparam logic [RowsW-1:0] RowsReset = 4'd8;
  localparam logic [ColsW-1:0] ColsReset = 5'd16;

  // One multiply-accumulate request, issued together with the store read addresses.
  typedef struct packed {
    logic issue;
    logic first;
  } mac_ctl_t;

endpackage

>>> src/linear_kernel_gram_matrix_core.sv
// Top level of the linear-kernel Gram matrix core: element store, MAC unit
// and sequencer. Depends on lkgm_pkg, lkgm_store, lkgm_mac and lkgm_seq.
//
// The core loads rows_in_use x cols_in_use signed Q8.8 elements in row-major
// order, one per cycle, into a two-read-port element store. The transaction
// that completes the matrix starts the compute phase, during which the input
// is stalled. One MAC unit forms each entry (i,j) as the dot product of rows i
// and j, with one store read pair per term followed by the read, multiply and
// accumulate stages. Entries leave in row-major order as full-precision Q20.16
// values with their indexes, the final one marked by last_entry_o; an output
// stall holds the compute. A write to either configuration register restarts
// the load.
module linear_kernel_gram_matrix_core #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [lkgm_pkg::ElemW-1:0] element_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [lkgm_pkg::KernW-1:0] kernel_value_o,
  output logic [lkgm_pkg::IdxW-1:0]         row_index_o,
  output logic [lkgm_pkg::IdxW-1:0]         col_index_o,
  output logic                              last_entry_o,
  input  logic                              cfg_we_i,
  input  logic [lkgm_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [lkgm_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int Depth = MAX_ROWS * MAX_COLS;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic                              wr_en;
  logic [AddrW-1:0]                  wr_addr;
  logic [AddrW-1:0]                  rd_addr_a;
  logic [AddrW-1:0]                  rd_addr_b;
  logic signed [lkgm_pkg::ElemW-1:0] rd_data_a;
  logic signed [lkgm_pkg::ElemW-1:0] rd_data_b;
  lkgm_pkg::mac_ctl_t                mac_ctl;
  logic                              mac_busy;
  logic [lkgm_pkg::KernW-1:0]        acc;

  // Element store.
  lkgm_store #(
    .Depth(Depth),
    .AddrW(AddrW)
  ) u_store (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (element_value_i),
    .rd_addr_a_i(rd_addr_a),
    .rd_addr_b_i(rd_addr_b),
    .rd_data_a_o(rd_data_a),
    .rd_data_b_o(rd_data_b)
  );

  // Multiply-accumulate unit.
  lkgm_mac u_mac (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (mac_ctl),
    .a_i   (rd_data_a),
    .b_i   (rd_data_b),
    .busy_o(mac_busy),
    .acc_o (acc)
  );

  // Sequencer with configuration and output register.
  lkgm_seq #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS),
    .AddrW   (AddrW)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .wr_en_o       (wr_en),
    .wr_addr_o     (wr_addr),
    .rd_addr_a_o   (rd_addr_a),
    .rd_addr_b_o   (rd_addr_b),
    .mac_ctl_o     (mac_ctl),
    .mac_busy_i    (mac_busy),
    .acc_i         (acc),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kernel_value_o(kernel_value_o),
    .row_index_o   (row_index_o),
    .col_index_o   (col_index_o),
    .last_entry_o  (last_entry_o)
  );

endmodule

>>> src/lkgm_store.sv
// Element store of the Gram matrix core: one write port and two read ports
// with registered read data. Depends on lkgm_pkg.
module lkgm_store #(
  parameter int Depth = 128,
  parameter int AddrW = 7
) (
  input  logic                              clk_i,
  input  logic                              wr_en_i,
  input  logic [AddrW-1:0]                  wr_addr_i,
  input  logic signed [lkgm_pkg::ElemW-1:0] wr_data_i,
  input  logic [AddrW-1:0]                  rd_addr_a_i,
  input  logic [AddrW-1:0]                  rd_addr_b_i,
  output logic signed [lkgm_pkg::ElemW-1:0] rd_data_a_o,
  output logic signed [lkgm_pkg::ElemW-1:0] rd_data_b_o
);

  logic [lkgm_pkg::ElemW-1:0] mem [Depth];
  logic [lkgm_pkg::ElemW-1:0] rd_a_q;
  logic [lkgm_pkg::ElemW-1:0] rd_b_q;

  // Writes happen only while loading and read data is used only while computing,
  // so no used read meets a write to the same entry in the same cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_a_q <= mem[rd_addr_a_i];
    rd_b_q <= mem[rd_addr_b_i];
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule

>>> src/lkgm_mac.sv
// Multiply-accumulate unit of the Gram matrix core: a registered product stage
// followed by a 36-bit accumulator. Depends on lkgm_pkg.
module lkgm_mac (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lkgm_pkg::mac_ctl_t                ctl_i,
  input  logic signed [lkgm_pkg::ElemW-1:0] a_i,
  input  logic signed [lkgm_pkg::ElemW-1:0] b_i,
  output logic                              busy_o,
  output logic [lkgm_pkg::KernW-1:0]        acc_o
);

  lkgm_pkg::mac_ctl_t                ctl1_q;
  lkgm_pkg::mac_ctl_t                ctl2_q;
  logic signed [lkgm_pkg::ProdW-1:0] prod_q;
  logic [lkgm_pkg::KernW-1:0]        acc_q;
  logic [lkgm_pkg::KernW-1:0]        prod_ext;

  // Control follows the data: stage one lines up with the store read data,
  // stage two with the registered product.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
    end
  end

  // Sign-extend the product to the accumulator width.
  assign prod_ext = {{(lkgm_pkg::KernW - lkgm_pkg::ProdW){prod_q[lkgm_pkg::ProdW-1]}}, prod_q};

  // Product register, then accumulate; the first term of a sum restarts it.
  // The sum wraps modulo 2^36.
  always_ff @(posedge clk_i) begin
    if (ctl1_q.issue) begin
      prod_q <= a_i * b_i;
    end
    if (ctl2_q.issue) begin
      acc_q <= (ctl2_q.first ? '0 : acc_q) + prod_ext;
    end
  end

  assign busy_o = ctl1_q.issue | ctl2_q.issue;
  assign acc_o  = acc_q;

endmodule

>>> src/lkgm_seq.sv
// Sequencer of the Gram matrix core: configuration registers, load counter,
// row/column/term counters, store addressing and the output register.
// Depends on lkgm_pkg.
module lkgm_seq #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 16,
  parameter int AddrW    = 7
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input channel handshake.
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  // Configuration port.
  input  logic                                cfg_we_i,
  input  logic [lkgm_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [lkgm_pkg::CfgDataW-1:0]       cfg_data_i,
  // Store addressing.
  output logic                                wr_en_o,
  output logic [AddrW-1:0]                    wr_addr_o,
  output logic [AddrW-1:0]                    rd_addr_a_o,
  output logic [AddrW-1:0]                    rd_addr_b_o,
  // MAC unit.
  output lkgm_pkg::mac_ctl_t                  mac_ctl_o,
  input  logic                                mac_busy_i,
  input  logic [lkgm_pkg::KernW-1:0]          acc_i,
  // Output channel.
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [lkgm_pkg::KernW-1:0]   kernel_value_o,
  output logic [lkgm_pkg::IdxW-1:0]           row_index_o,
  output logic [lkgm_pkg::IdxW-1:0]           col_index_o,
  output logic                                last_entry_o
);

  localparam int Depth = MAX_ROWS * MAX_COLS;
  localparam int CntW  = $clog2(Depth + 1);
  localparam int TotW  = lkgm_pkg::RowsW + lkgm_pkg::ColsW;

  typedef enum logic [1:0] {
    StLoad,
    StMac,
    StDrain
  } state_e;

  state_e                        state_q;
  logic [lkgm_pkg::RowsW-1:0]    rows_cfg_q;
  logic [lkgm_pkg::ColsW-1:0]    cols_cfg_q;
  logic [CntW-1:0]               cnt_q;
  logic [lkgm_pkg::IdxW-1:0]     i_q;
  logic [lkgm_pkg::IdxW-1:0]     j_q;
  logic [lkgm_pkg::ColsW-1:0]    k_q;
  logic [AddrW-1:0]              base_i_q;
  logic [AddrW-1:0]              base_j_q;
  logic                          out_valid_q;
  logic [lkgm_pkg::KernW-1:0]    kernel_q;
  logic [lkgm_pkg::IdxW-1:0]     row_q;
  logic [lkgm_pkg::IdxW-1:0]     col_q;
  logic                          last_q;

  logic [lkgm_pkg::RowsW-1:0]    eff_rows;
  logic [lkgm_pkg::ColsW-1:0]    eff_cols;
  logic [TotW-1:0]               total;
  logic [TotW-1:0]               cnt_inc;
  logic                          in_acc;
  logic                          k_last;
  logic                          i_last;
  logic                          j_last;
  logic                          entry_last;
  logic                          out_free;
  logic                          push;

  // Clamp the register values to the supported range.
  always_comb begin
    eff_rows = rows_cfg_q;
    if (rows_cfg_q == '0) begin
      eff_rows = lkgm_pkg::RowsW'(1);
    end else if (int'(rows_cfg_q) > MAX_ROWS) begin
      eff_rows = lkgm_pkg::RowsW'(MAX_ROWS);
    end
    eff_cols = cols_cfg_q;
    if (cols_cfg_q == '0) begin
      eff_cols = lkgm_pkg::ColsW'(1);
    end else if (int'(cols_cfg_q) > MAX_COLS) begin
      eff_cols = lkgm_pkg::ColsW'(MAX_COLS);
    end
  end

  assign total   = TotW'(eff_rows) * TotW'(eff_cols);
  assign cnt_inc = TotW'(cnt_q) + TotW'(1);

  // Handshake and loop conditions.
  assign in_stall_o = (state_q != StLoad);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign k_last     = (k_q == eff_cols - lkgm_pkg::ColsW'(1));
  assign i_last     = (lkgm_pkg::RowsW'(i_q) == eff_rows - lkgm_pkg::RowsW'(1));
  assign j_last     = (lkgm_pkg::RowsW'(j_q) == eff_rows - lkgm_pkg::RowsW'(1));
  assign entry_last = i_last & j_last;
  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign push       = (state_q == StDrain) & ~mac_busy_i & out_free;

  // Elements are stored in row-major order, so the load count is the address.
  assign wr_en_o     = in_acc;
  assign wr_addr_o   = cnt_q[AddrW-1:0];
  assign rd_addr_a_o = base_i_q + AddrW'(k_q);
  assign rd_addr_b_o = base_j_q + AddrW'(k_q);

  assign mac_ctl_o.issue = (state_q == StMac);
  assign mac_ctl_o.first = (k_q == '0);

  // State, counters, configuration and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      rows_cfg_q  <= lkgm_pkg::RowsReset;
      cols_cfg_q  <= lkgm_pkg::ColsReset;
      cnt_q       <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      base_i_q    <= '0;
      base_j_q    <= '0;
      out_valid_q <= 1'b0;
      kernel_q    <= '0;
      row_q       <= '0;
      col_q       <= '0;
      last_q      <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StLoad: begin
          if (in_acc) begin
            if (cnt_inc == total) begin
              cnt_q    <= '0;
              i_q      <= '0;
              j_q      <= '0;
              k_q      <= '0;
              base_i_q <= '0;
              base_j_q <= '0;
              state_q  <= StMac;
            end else begin
              cnt_q <= CntW'(cnt_inc);
            end
          end
        end
        StMac: begin
          if (k_last) begin
            k_q     <= '0;
            state_q <= StDrain;
          end else begin
            k_q <= k_q + lkgm_pkg::ColsW'(1);
          end
        end
        StDrain: begin
          if (push) begin
            out_valid_q <= 1'b1;
            kernel_q    <= acc_i;
            row_q       <= i_q;
            col_q       <= j_q;
            last_q      <= entry_last;
            if (j_last) begin
              j_q      <= '0;
              base_j_q <= '0;
              i_q      <= i_q + lkgm_pkg::IdxW'(1);
              base_i_q <= base_i_q + AddrW'(eff_cols);
            end else begin
              j_q      <= j_q + lkgm_pkg::IdxW'(1);
              base_j_q <= base_j_q + AddrW'(eff_cols);
            end
            state_q <= entry_last ? StLoad : StMac;
          end
        end
        default: begin
          state_q <= StLoad;
        end
      endcase
      // A write to either configuration register drops any partial load.
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          lkgm_pkg::CfgRowsInUse: begin
            rows_cfg_q <= cfg_data_i[lkgm_pkg::RowsW-1:0];
            cnt_q      <= '0;
          end
          lkgm_pkg::CfgColsInUse: begin
            cols_cfg_q <= cfg_data_i[lkgm_pkg::ColsW-1:0];
            cnt_q      <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kernel_value_o = kernel_q;
  assign row_index_o    = row_q;
  assign col_index_o    = col_q;
  assign last_entry_o   = last_q;

endmodule

>>> src/lkgm_checker.sv
// Port-level checker for the Gram matrix core and the bind that attaches it.
// Depends on lkgm_pkg and linear_kernel_gram_matrix_core.
module lkgm_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [lkgm_pkg::KernW-1:0] kernel_value_o,
  input logic [lkgm_pkg::IdxW-1:0]         row_index_o,
  input logic [lkgm_pkg::IdxW-1:0]         col_index_o,
  input logic                              last_entry_o
);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kernel_value_o) &&
      $stable(row_index_o) && $stable(col_index_o) && $stable(last_entry_o))
    else $error("stalled result changed");

  // The final entry sits on the diagonal.
  a_last_diag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_entry_o |-> row_index_o == col_index_o)
    else $error("final entry is off the diagonal");

  // While entries remain to be computed, no element is taken.
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_entry_o |-> in_stall_o)
    else $error("input open before the matrix was emitted");

  // The compute phase starts only on an accepted element.
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("compute started without an element transaction");

endmodule

bind linear_kernel_gram_matrix_core lkgm_checker u_lkgm_checker (.*);
